FILE: rtl/sas_pkg.sv
// Shared types and constants of the sensor alarm supervisor.
package sas_pkg;

  // Profile count and long key press length in ticks.
  localparam int unsigned PROFILES         = 4;
  localparam int unsigned LONG_PRESS_TICKS = 1200;

  // Blink half periods in ticks.
  localparam int unsigned FAST_BLINK = 150;
  localparam int unsigned SLOW_BLINK = 700;

  // RGB levels per class.
  localparam logic [7:0] RGB_DANGER_HI = 8'd96;
  localparam logic [7:0] RGB_DANGER_LO = 8'd18;
  localparam logic [7:0] RGB_LOST_HI   = 8'd80;
  localparam logic [7:0] RGB_LOST_LO   = 8'd12;
  localparam logic [7:0] RGB_WARN_RED  = 8'd72;
  localparam logic [7:0] RGB_WARN_GRN  = 8'd32;
  localparam logic [7:0] RGB_NORM_GRN  = 8'd54;
  localparam logic [7:0] RGB_WAIT_BLU  = 8'd28;

  // Register indexes.
  localparam logic [2:0] REG_SMOKE_WARN   = 3'd0;
  localparam logic [2:0] REG_SMOKE_DANGER = 3'd1;
  localparam logic [2:0] REG_AIR_WARN     = 3'd2;
  localparam logic [2:0] REG_RAIN_WARN    = 3'd3;
  localparam logic [2:0] REG_HEAT_WARN    = 3'd4;
  localparam logic [2:0] REG_HEAT_DANGER  = 3'd5;
  localparam logic [2:0] REG_LOST_TIMEOUT = 3'd6;
  localparam logic [2:0] REG_MUTE_LENGTH  = 3'd7;

  // Alarm class codes.
  typedef enum logic [2:0] {
    CLASS_WAITING = 3'd0,
    CLASS_NORMAL  = 3'd1,
    CLASS_WARN    = 3'd2,
    CLASS_DANGER  = 3'd3,
    CLASS_LOST    = 3'd4
  } alarm_class_t;

  // Configuration register contents.
  typedef struct packed {
    logic [11:0]        smoke_warn_level;
    logic [11:0]        smoke_danger_level;
    logic [11:0]        air_warn_level;
    logic [11:0]        rain_warn_level;
    logic signed [15:0] heat_warn_tenths;
    logic signed [15:0] heat_danger_tenths;
    logic [19:0]        lost_timeout_ticks;
    logic [19:0]        mute_length_ticks;
  } cfg_t;

  // Held sensor frame, packed as on the input bus.
  typedef struct packed {
    logic signed [15:0] probe_tenths;
    logic [11:0]        rain_reading;
    logic [11:0]        air_reading;
    logic [11:0]        smoke_reading;
    logic               probe_fault;
    logic               humidity_fault;
    logic               rain_flag;
    logic               probe_hot;
    logic               flame_seen;
  } frame_t;

  // Per-tick snapshot handed from the state stage to the classify stage.
  typedef struct packed {
    frame_t     frame;
    logic       waiting;
    logic       lost;
    logic       muted;
    logic [1:0] profile;
    logic       fast_phase;
    logic       slow_phase;
  } snap_t;

endpackage

FILE: rtl/sas_cfg.sv
// APB register file holding the threshold and timing settings.
module sas_cfg
  import sas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoke_warn_level   <= 12'd1500;
      cfg.smoke_danger_level <= 12'd2500;
      cfg.air_warn_level     <= 12'd2000;
      cfg.rain_warn_level    <= 12'd3000;
      cfg.heat_warn_tenths   <= 16'sd450;
      cfg.heat_danger_tenths <= 16'sd600;
      cfg.lost_timeout_ticks <= 20'd3000;
      cfg.mute_length_ticks  <= 20'd60000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SMOKE_WARN:   cfg.smoke_warn_level   <= pwdata[11:0];
        REG_SMOKE_DANGER: cfg.smoke_danger_level <= pwdata[11:0];
        REG_AIR_WARN:     cfg.air_warn_level     <= pwdata[11:0];
        REG_RAIN_WARN:    cfg.rain_warn_level    <= pwdata[11:0];
        REG_HEAT_WARN:    cfg.heat_warn_tenths   <= pwdata[15:0];
        REG_HEAT_DANGER:  cfg.heat_danger_tenths <= pwdata[15:0];
        REG_LOST_TIMEOUT: cfg.lost_timeout_ticks <= pwdata[19:0];
        REG_MUTE_LENGTH:  cfg.mute_length_ticks  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      REG_SMOKE_WARN:   prdata = {20'd0, cfg.smoke_warn_level};
      REG_SMOKE_DANGER: prdata = {20'd0, cfg.smoke_danger_level};
      REG_AIR_WARN:     prdata = {20'd0, cfg.air_warn_level};
      REG_RAIN_WARN:    prdata = {20'd0, cfg.rain_warn_level};
      REG_HEAT_WARN:    prdata = {16'd0, cfg.heat_warn_tenths};
      REG_HEAT_DANGER:  prdata = {16'd0, cfg.heat_danger_tenths};
      REG_LOST_TIMEOUT: prdata = {12'd0, cfg.lost_timeout_ticks};
      REG_MUTE_LENGTH:  prdata = {12'd0, cfg.mute_length_ticks};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/sas_state.sv
// Tick state: time, held frame, key handling, mute deadline and blink phases.
module sas_state
  import sas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic        frame_valid,
  input  frame_t      frame_in,
  input  logic        key_level,
  output snap_t       snap
);

  localparam logic [7:0] FAST_LAST = 8'(FAST_BLINK - 1);
  localparam logic [9:0] SLOW_LAST = 10'(SLOW_BLINK - 1);

  logic [31:0] tick_now;
  logic [31:0] last_frame_tick;
  logic        frame_seen;
  frame_t      held_frame;
  logic [31:0] mute_deadline;
  logic        key_prev;
  logic [31:0] key_down_tick;
  logic [1:0]  profile_sel;
  logic [7:0]  fast_cnt;
  logic        fast_odd;
  logic [9:0]  slow_cnt;
  logic        slow_odd;

  logic        frame_seen_next;
  frame_t      held_frame_next;
  logic [31:0] last_frame_tick_next;
  logic [31:0] mute_deadline_next;
  logic [31:0] key_down_tick_next;
  logic [1:0]  profile_sel_next;
  logic        press;
  logic        release_key;
  logic        long_press;
  logic [31:0] since_frame;
  logic [31:0] to_deadline;
  logic        lost;
  logic        muted;
  logic        tick_wrap;

  // Next state of one tick.
  always_comb begin
    press       = key_level && !key_prev;
    release_key = !key_level && key_prev;
    long_press  = (tick_now - key_down_tick) >= 32'(LONG_PRESS_TICKS);

    frame_seen_next      = frame_seen || frame_valid;
    held_frame_next      = frame_valid ? frame_in : held_frame;
    last_frame_tick_next = frame_valid ? tick_now : last_frame_tick;

    key_down_tick_next = press ? tick_now : key_down_tick;
    profile_sel_next   = profile_sel;
    mute_deadline_next = mute_deadline;
    if (release_key && long_press) begin
      profile_sel_next = (32'(profile_sel) == PROFILES - 1) ? 2'd0 : profile_sel + 2'd1;
    end else if (release_key) begin
      mute_deadline_next = tick_now + {12'd0, cfg.mute_length_ticks};
    end

    // A frame this tick leaves zero elapsed ticks, which is never lost.
    since_frame = tick_now - last_frame_tick;
    lost        = !frame_valid && (since_frame > {12'd0, cfg.lost_timeout_ticks});

    // A fresh mute leaves exactly the mute length ahead.
    to_deadline = mute_deadline - tick_now;
    if (release_key && !long_press) begin
      muted = cfg.mute_length_ticks != 20'd0;
    end else begin
      muted = (to_deadline != 32'd0) && !to_deadline[31];
    end

    tick_wrap = &tick_now;
  end

  // Snapshot for the classify stage.
  always_comb begin
    snap.frame      = held_frame_next;
    snap.lost       = lost;
    snap.waiting    = !frame_seen_next && !lost;
    snap.muted      = muted;
    snap.profile    = profile_sel_next;
    snap.fast_phase = !fast_odd;
    snap.slow_phase = !slow_odd;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now        <= 32'd0;
      last_frame_tick <= 32'd0;
      frame_seen      <= 1'b0;
      held_frame      <= '0;
      mute_deadline   <= 32'd0;
      key_prev        <= 1'b0;
      key_down_tick   <= 32'd0;
      profile_sel     <= 2'd0;
      fast_cnt        <= 8'd0;
      fast_odd        <= 1'b0;
      slow_cnt        <= 10'd0;
      slow_odd        <= 1'b0;
    end else if (accept) begin
      tick_now        <= tick_now + 32'd1;
      last_frame_tick <= last_frame_tick_next;
      frame_seen      <= frame_seen_next;
      held_frame      <= held_frame_next;
      mute_deadline   <= mute_deadline_next;
      key_prev        <= key_level;
      key_down_tick   <= key_down_tick_next;
      profile_sel     <= profile_sel_next;
      // Blink phases follow tick_now divided by the half period.
      if (tick_wrap) begin
        fast_cnt <= 8'd0;
        fast_odd <= 1'b0;
        slow_cnt <= 10'd0;
        slow_odd <= 1'b0;
      end else begin
        if (fast_cnt == FAST_LAST) begin
          fast_cnt <= 8'd0;
          fast_odd <= !fast_odd;
        end else begin
          fast_cnt <= fast_cnt + 8'd1;
        end
        if (slow_cnt == SLOW_LAST) begin
          slow_cnt <= 10'd0;
          slow_odd <= !slow_odd;
        end else begin
          slow_cnt <= slow_cnt + 10'd1;
        end
      end
    end
  end

endmodule

FILE: rtl/sas_classify.sv
// Alarm classification and indicator drive from one tick snapshot.
module sas_classify
  import sas_pkg::*;
(
  input  cfg_t        cfg,
  input  snap_t       snap,
  output logic [33:0] result
);

  frame_t       f;
  logic         temp_ok;
  logic         danger;
  logic         warn;
  alarm_class_t cls;
  logic         buz;
  logic         lr;
  logic         lg;
  logic         lb;
  logic [7:0]   rr;
  logic [7:0]   rg;
  logic [7:0]   rb;

  always_comb begin
    f       = snap.frame;
    temp_ok = !f.probe_fault;
    danger  = 1'b0;
    warn    = 1'b0;
    // Thresholds are judged only with a live frame.
    if (!snap.waiting && !snap.lost) begin
      danger = f.flame_seen || (f.smoke_reading >= cfg.smoke_danger_level) ||
               f.probe_hot ||
               (temp_ok && (f.probe_tenths >= cfg.heat_danger_tenths));
      warn   = f.humidity_fault || (f.air_reading >= cfg.air_warn_level) ||
               (f.smoke_reading >= cfg.smoke_warn_level) || f.rain_flag ||
               (f.rain_reading >= cfg.rain_warn_level) ||
               (temp_ok && (f.probe_tenths >= cfg.heat_warn_tenths));
    end

    // Priority: danger, waiting, node lost, warn, normal.
    buz = 1'b0;
    rr  = 8'd0;
    rg  = 8'd0;
    rb  = 8'd0;
    if (danger) begin
      cls = CLASS_DANGER;
      lr = 1'b1; lg = 1'b0; lb = 1'b0;
      rr  = snap.fast_phase ? RGB_DANGER_HI : RGB_DANGER_LO;
      buz = !snap.muted && snap.fast_phase;
    end else if (snap.waiting) begin
      cls = CLASS_WAITING;
      lr = 1'b0; lg = 1'b0; lb = 1'b1;
      rb  = RGB_WAIT_BLU;
    end else if (snap.lost) begin
      cls = CLASS_LOST;
      lr = 1'b0; lg = 1'b0; lb = 1'b1;
      rb  = snap.slow_phase ? RGB_LOST_HI : RGB_LOST_LO;
      buz = !snap.muted && snap.slow_phase;
    end else if (warn) begin
      cls = CLASS_WARN;
      lr = 1'b1; lg = 1'b1; lb = 1'b0;
      rr  = RGB_WARN_RED;
      rg  = RGB_WARN_GRN;
    end else begin
      cls = CLASS_NORMAL;
      lr = 1'b0; lg = 1'b1; lb = 1'b0;
      rg  = RGB_NORM_GRN;
    end

    result = {snap.profile, snap.muted, rb, rg, rr, lb, lg, lr, buz, cls};
  end

endmodule

FILE: rtl/sensor_alarm_supervisor_top.sv
// Top level of the sensor alarm supervisor: stream ports, APB port, two stages.
//
// Channel | Direction | Transaction content
// s_*     | in        | one millisecond tick: frame (if s_tuser) and key level
// m_*     | out       | one indicator result per tick
// APB     | in/out    | threshold and timing registers at 4*index
//
// One tick per clock cycle is sustained while m_tready is high; each tick passes
// the snapshot register after the state stage and the result register after
// classification. Reset is synchronous and active high and restores every register
// but the snapshot and result data registers. A stall on m_tready fills the snapshot
// register and then holds s_tready low until the result is taken.
module sensor_alarm_supervisor_top
  import sas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] flame_seen, [1] probe_hot, [2] rain_flag, [3] humidity_fault,
  // [4] probe_fault, [16:5] smoke_reading, [28:17] air_reading,
  // [40:29] rain_reading, [56:41] probe_tenths, [57] key_level, rest zero
  input  logic [63:0] s_tdata,
  // [0] frame_valid
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] alarm_class, [3] buzzer_on, [4] led_red, [5] led_green,
  // [6] led_blue, [14:7] rgb_red, [22:15] rgb_green, [30:23] rgb_blue,
  // [31] mute_active, [33:32] profile_index, rest zero
  output logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  snap_t       snap_next;
  snap_t       snap;
  logic        snap_valid;
  logic        s_accept;
  logic        snap_move;
  logic [33:0] result_next;
  logic [33:0] result;

  // Handshake between the stages.
  assign snap_move = snap_valid && (!m_tvalid || m_tready);
  assign s_tready  = !snap_valid || snap_move;
  assign s_accept  = s_tvalid && s_tready;

  sas_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sas_state u_state (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (s_accept),
    .frame_valid (s_tuser),
    .frame_in    (frame_t'(s_tdata[56:0])),
    .key_level   (s_tdata[57]),
    .snap        (snap_next)
  );

  sas_classify u_classify (
    .cfg    (cfg),
    .snap   (snap),
    .result (result_next)
  );

  // Snapshot and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_accept) begin
        snap_valid <= 1'b1;
      end else if (snap_move) begin
        snap_valid <= 1'b0;
      end
      if (snap_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      snap <= snap_next;
    end
    if (snap_move) begin
      result <= result_next;
    end
  end

  assign m_tdata = {6'd0, result};

endmodule
